// ===== hw/rtl/tbp_pkg.sv =====
// Package for the tournament branch predictor: table sizes, operation codes,
// counter thresholds, saturating counter functions and the clear-pass struct.
// It depends on nothing else and is imported by tbp_clear, tbp_out_fifo and the top level.
package tbp_pkg;

	localparam int GLOBAL_HIST_BITS = 12;
	localparam int LOCAL_HIST_BITS  = 10;
	localparam int GLOBAL_SIZE      = 1 << GLOBAL_HIST_BITS;
	localparam int LOCAL_SIZE       = 1 << LOCAL_HIST_BITS;

	localparam int CLR_BITS = (GLOBAL_HIST_BITS > LOCAL_HIST_BITS) ?
		GLOBAL_HIST_BITS : LOCAL_HIST_BITS;
	localparam int CLR_W    = CLR_BITS + 1;
	localparam int CLR_SIZE = 1 << CLR_BITS;

	localparam int OUT_DEPTH    = 4;
	localparam int OUT_PTR_BITS = 2;
	localparam int OUT_CNT_W    = 3;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_TRAIN   = 1'b1;

	localparam logic [1:0] GCNT_RESET     = 2'd1;
	localparam logic [1:0] CHS_RESET      = 2'd1;
	localparam logic [2:0] LCNT_RESET     = 3'd3;
	localparam logic [1:0] GCNT_WEAK_NT   = 2'd1;
	localparam logic [1:0] CHS_WEAK_LOCAL = 2'd1;
	localparam logic [2:0] LCNT_WEAK_NT   = 3'd3;
	localparam logic [1:0] CNT2_TOP       = 2'd3;
	localparam logic [2:0] CNT3_TOP       = 3'd7;

	typedef struct packed {
		logic             busy;
		logic             glb_we;
		logic             lcl_we;
		logic [CLR_W-1:0] addr;
	} clr_t;

	function automatic logic [1:0] step2(input logic [1:0] value, input logic up);
		logic [1:0] res;
		if (up) begin
			res = (value == CNT2_TOP) ? value : 2'(value + 2'd1);
		end else begin
			res = (value == 2'd0) ? value : 2'(value - 2'd1);
		end
		return res;
	endfunction

	function automatic logic [2:0] step3(input logic [2:0] value, input logic up);
		logic [2:0] res;
		if (up) begin
			res = (value == CNT3_TOP) ? value : 3'(value + 3'd1);
		end else begin
			res = (value == 3'd0) ? value : 3'(value - 3'd1);
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/tbp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing; width and depth come from its parameters.
module tbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/tbp_clear.sv =====
// Clearing sequencer that sweeps all predictor tables to their reset values.
// It depends on tbp_pkg for the table sizes and the clr_t struct.
module tbp_clear
	import tbp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	output clr_t clr
);

	localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_SIZE - 1);
	localparam logic [CLR_W-1:0] LCL_LIMIT = CLR_W'(LOCAL_SIZE);
	localparam logic [CLR_W-1:0] GLB_LIMIT = CLR_W'(GLOBAL_SIZE);

	logic             busy_q;
	logic [CLR_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CLR_LAST) begin
				busy_q <= 1'b0;
			end
			cnt_q <= CLR_W'(cnt_q + 1'b1);
		end
	end

	always_comb begin
		clr.busy   = busy_q;
		clr.glb_we = busy_q && (cnt_q < GLB_LIMIT);
		clr.lcl_we = busy_q && (cnt_q < LCL_LIMIT);
		clr.addr   = cnt_q;
	end

	a_clear_ends_at_last : assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(cnt_q) == CLR_LAST)
		else $error("clear pass ended before sweeping every entry");

endmodule

// ===== hw/rtl/tbp_out_fifo.sv =====
// Small result queue that holds prediction words until the receiver takes them.
// It depends on tbp_pkg for its depth and pointer widths.
module tbp_out_fifo
	import tbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 push_data,
	input  logic                 pop,
	output logic                 head_valid,
	output logic                 head_data,
	output logic [OUT_CNT_W-1:0] count
);

	logic                    data_q [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0] wr_ptr_q;
	logic [OUT_PTR_BITS-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= OUT_PTR_BITS'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= OUT_PTR_BITS'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= OUT_CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= OUT_CNT_W'(count_q - 1'b1);
			end
		end
	end

	assign head_valid = (count_q != '0);
	assign head_data  = data_q[rd_ptr_q];
	assign count      = count_q;

	a_no_push_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < OUT_CNT_W'(OUT_DEPTH)) || pop)
		else $error("result queue overflow");

endmodule

// ===== hw/rtl/tournament_branch_predictor_unit.sv =====
// Top level of the tournament branch predictor: input register, table reads,
// forwarding, counter update and result queue. It depends on tbp_pkg,
// tbp_ram, tbp_clear and tbp_out_fifo.
//
// Usage: the input channel (in_valid/in_ready) carries one word per branch:
// operation selects predict or train, pc_addr picks the local history entry,
// taken is the resolved outcome for train. Each predict word yields one word
// on the output channel (out_valid/out_ready) holding predict_taken; train
// words yield nothing. Results leave in the order the predicts were accepted.
// Throughput is one word per cycle while in_ready is high. A predict result
// passes the local history read, then the counter and chooser reads, then
// enters a four-entry result queue from which it is offered to the receiver.
// After reset a clearing pass writes every table entry, one entry per cycle,
// and in_ready stays low until it completes. When the receiver
// stalls, results collect in the queue and in_ready drops once the queue and
// the predicts still in flight would fill it; nothing is lost or dropped.
module tournament_branch_predictor_unit
	import tbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] pc_addr,
	input  logic        taken,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        predict_taken
);

	localparam int GB = GLOBAL_HIST_BITS;
	localparam int LB = LOCAL_HIST_BITS;

	clr_t clr;

	logic accept;
	logic [GB-1:0] ghist_q;

	logic          valid_s1;
	logic          op_s1;
	logic          taken_s1;
	logic [LB-1:0] slot_s1;
	logic [GB-1:0] gidx_s1;

	logic          valid_s2;
	logic          op_s2;
	logic          taken_s2;
	logic [LB-1:0] slot_s2;
	logic [LB-1:0] lhist_new_s2;
	logic [LB-1:0] lidx_s2;
	logic [GB-1:0] gidx_s2;

	logic          fwd_valid_q;
	logic [LB-1:0] fwd_lidx_q;
	logic [GB-1:0] fwd_gidx_q;
	logic [2:0]    fwd_lcnt_q;
	logic [1:0]    fwd_gcnt_q;
	logic [1:0]    fwd_ccnt_q;

	logic [LB-1:0] lh_rdata;
	logic [LB-1:0] lhist;
	logic [LB-1:0] lhist_new;
	logic          lh_we;
	logic [LB-1:0] lh_waddr;
	logic [LB-1:0] lh_wdata;

	logic [2:0] lc_rdata;
	logic [1:0] gc_rdata;
	logic [1:0] cc_rdata;
	logic [2:0] lcnt;
	logic [1:0] gcnt;
	logic [1:0] ccnt;
	logic [2:0] lcnt_new;
	logic [1:0] gcnt_new;
	logic [1:0] ccnt_new;
	logic       local_pred;
	logic       global_pred;
	logic       use_global;
	logic       train_s2;

	logic          lc_we;
	logic [LB-1:0] lc_waddr;
	logic [2:0]    lc_wdata;
	logic          gc_we;
	logic [GB-1:0] gc_waddr;
	logic [1:0]    gc_wdata;
	logic [1:0]    cc_wdata;

	logic                 push;
	logic                 pop;
	logic [OUT_CNT_W-1:0] fifo_count;
	logic [OUT_CNT_W:0]   occupancy;

	tbp_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	// Room is reserved in the result queue for every predict still in flight.
	assign occupancy = (OUT_CNT_W+1)'(fifo_count)
		+ (OUT_CNT_W+1)'(valid_s1 && (op_s1 == OP_PREDICT))
		+ (OUT_CNT_W+1)'(valid_s2 && (op_s2 == OP_PREDICT));
	assign in_ready = !clr.busy && (occupancy < (OUT_CNT_W+1)'(OUT_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist_q     <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (accept && (operation == OP_TRAIN)) begin
				ghist_q <= GB'({ghist_q, taken});
			end
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			fwd_valid_q <= train_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			taken_s1 <= taken;
			slot_s1  <= pc_addr[LB-1:0];
			gidx_s1  <= ghist_q;
		end
		op_s2        <= op_s1;
		taken_s2     <= taken_s1;
		slot_s2      <= slot_s1;
		lhist_new_s2 <= lhist_new;
		lidx_s2      <= lhist;
		gidx_s2      <= gidx_s1;
		fwd_lidx_q   <= lidx_s2;
		fwd_gidx_q   <= gidx_s2;
		fwd_lcnt_q   <= lcnt_new;
		fwd_gcnt_q   <= gcnt_new;
		fwd_ccnt_q   <= ccnt_new;
	end

	// The train one stage ahead wrote its history on the edge that read ours.
	always_comb begin
		if (valid_s2 && (op_s2 == OP_TRAIN) && (slot_s2 == slot_s1)) begin
			lhist = lhist_new_s2;
		end else begin
			lhist = lh_rdata;
		end
		lhist_new = LB'({lhist, taken_s1});
		lh_we     = clr.lcl_we || (valid_s1 && (op_s1 == OP_TRAIN));
		lh_waddr  = clr.busy ? clr.addr[LB-1:0] : slot_s1;
		lh_wdata  = clr.busy ? '0 : lhist_new;
	end

	tbp_ram #(.WIDTH(LB), .DEPTH(LOCAL_SIZE)) u_local_hist (
		.clk     (clk),
		.wr_en   (lh_we),
		.wr_addr (lh_waddr),
		.wr_data (lh_wdata),
		.rd_en   (accept),
		.rd_addr (pc_addr[LB-1:0]),
		.rd_data (lh_rdata)
	);

	// The counters written on the previous edge are taken from the bypass.
	always_comb begin
		train_s2 = valid_s2 && (op_s2 == OP_TRAIN);
		if (fwd_valid_q && (fwd_lidx_q == lidx_s2)) begin
			lcnt = fwd_lcnt_q;
		end else begin
			lcnt = lc_rdata;
		end
		if (fwd_valid_q && (fwd_gidx_q == gidx_s2)) begin
			gcnt = fwd_gcnt_q;
			ccnt = fwd_ccnt_q;
		end else begin
			gcnt = gc_rdata;
			ccnt = cc_rdata;
		end
		local_pred  = (lcnt > LCNT_WEAK_NT);
		global_pred = (gcnt > GCNT_WEAK_NT);
		use_global  = (ccnt > CHS_WEAK_LOCAL);
		lcnt_new    = step3(lcnt, taken_s2);
		gcnt_new    = step2(gcnt, taken_s2);
		if (global_pred != local_pred) begin
			ccnt_new = step2(ccnt, global_pred == taken_s2);
		end else begin
			ccnt_new = ccnt;
		end
		lc_we    = clr.lcl_we || train_s2;
		lc_waddr = clr.busy ? clr.addr[LB-1:0] : lidx_s2;
		lc_wdata = clr.busy ? LCNT_RESET : lcnt_new;
		gc_we    = clr.glb_we || train_s2;
		gc_waddr = clr.busy ? clr.addr[GB-1:0] : gidx_s2;
		gc_wdata = clr.busy ? GCNT_RESET : gcnt_new;
		cc_wdata = clr.busy ? CHS_RESET : ccnt_new;
	end

	tbp_ram #(.WIDTH(3), .DEPTH(LOCAL_SIZE)) u_local_cnt (
		.clk     (clk),
		.wr_en   (lc_we),
		.wr_addr (lc_waddr),
		.wr_data (lc_wdata),
		.rd_en   (valid_s1),
		.rd_addr (lhist),
		.rd_data (lc_rdata)
	);

	tbp_ram #(.WIDTH(2), .DEPTH(GLOBAL_SIZE)) u_global_cnt (
		.clk     (clk),
		.wr_en   (gc_we),
		.wr_addr (gc_waddr),
		.wr_data (gc_wdata),
		.rd_en   (valid_s1),
		.rd_addr (gidx_s1),
		.rd_data (gc_rdata)
	);

	tbp_ram #(.WIDTH(2), .DEPTH(GLOBAL_SIZE)) u_chooser_cnt (
		.clk     (clk),
		.wr_en   (gc_we),
		.wr_addr (gc_waddr),
		.wr_data (cc_wdata),
		.rd_en   (valid_s1),
		.rd_addr (gidx_s1),
		.rd_data (cc_rdata)
	);

	assign push = valid_s2 && (op_s2 == OP_PREDICT);
	assign pop  = out_valid && out_ready;

	tbp_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (use_global ? global_pred : local_pred),
		.pop        (pop),
		.head_valid (out_valid),
		.head_data  (predict_taken),
		.count      (fifo_count)
	);

	a_no_items_during_clear : assert property (@(posedge clk) disable iff (!arst_n)
		clr.busy |-> !valid_s1 && !valid_s2 && !fwd_valid_q)
		else $error("item in flight during the clearing pass");

	a_occupancy_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (OUT_CNT_W+1)'(OUT_DEPTH))
		else $error("predicts in flight exceed result queue space");

	a_stage_follows : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 ##1 valid_s2)
		else $error("accepted word did not advance through the stages");

endmodule
